// File: rtl/core/vga_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vga_pkg
// Shared types and constants of the voice group allocator.
// ----------------------------------------------------------------------------
package vga_pkg;

  localparam int DEF_MAX_GROUPS  = 4;
  localparam int DEF_SERIAL_BITS = 32;

  localparam int OP_W     = 2;
  localparam int NOTE_W   = 7;
  localparam int MASK_W   = 4;
  localparam int GROUP_W  = 2;
  localparam int ACTION_W = 2;
  localparam int ACTIVE_W = 3;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd1;

  typedef enum logic [OP_W-1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_ALL_OFF  = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_IDLE  = 2'd0,
    ACT_REUSE = 2'd1,
    ACT_STEAL = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    logic clear;
    logic stamp;
    logic release_grp;
  } grp_cmd_t;

  typedef struct packed {
    logic gate;
    logic env;
    logic note_eq;
  } scan_elem_t;

endpackage
`default_nettype wire

// File: rtl/core/vga_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vga_ifs
// Valid/ready channels of the voice group allocator.
// ----------------------------------------------------------------------------
interface vga_in_if import vga_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [NOTE_W-1:0] note;
  logic [MASK_W-1:0] env_active_mask;

  modport source (output valid, output operation, output note, output env_active_mask,
                  input ready);
  modport sink (input valid, input operation, input note, input env_active_mask,
                output ready);
endinterface

interface vga_out_if import vga_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [GROUP_W-1:0]  group;
  logic                matched;
  logic [ACTION_W-1:0] action;

  modport source (output valid, output group, output matched, output action, input ready);
  modport sink (input valid, input group, input matched, input action, output ready);
endinterface

interface vga_cfg_if import vga_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTIVE_W-1:0] active_groups;

  modport source (output valid, output active_groups, input ready);
  modport sink (input valid, input active_groups, output ready);
endinterface
`default_nettype wire

// File: rtl/core/vga_group_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vga_group_regs
// Per-group gate, note and allocation serial storage with the serial counter.
// ----------------------------------------------------------------------------
module vga_group_regs import vga_pkg::*; #(
  parameter int MAX_GROUPS  = DEF_MAX_GROUPS,
  parameter int SERIAL_BITS = DEF_SERIAL_BITS,
  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire grp_cmd_t               cmd,
  input  wire logic [GW-1:0]          wr_idx,
  input  wire logic [NOTE_W-1:0]      wr_note,
  input  wire logic [GW-1:0]          rd_idx,
  output logic                        rd_gate,
  output logic [NOTE_W-1:0]           rd_note,
  output logic [SERIAL_BITS-1:0]      rd_serial
);

  logic                   gate_r   [MAX_GROUPS];
  logic [NOTE_W-1:0]      note_r   [MAX_GROUPS];
  logic [SERIAL_BITS-1:0] serial_r [MAX_GROUPS];
  logic [SERIAL_BITS-1:0] next_serial_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < MAX_GROUPS; g++) begin
        gate_r[g]   <= 1'b0;
        serial_r[g] <= '0;
      end
      next_serial_r <= SERIAL_BITS'(1);
    end else if (cmd.clear) begin
      for (int g = 0; g < MAX_GROUPS; g++) begin
        gate_r[g]   <= 1'b0;
        serial_r[g] <= '0;
      end
      next_serial_r <= SERIAL_BITS'(1);
    end else if (cmd.stamp) begin
      gate_r[wr_idx]   <= 1'b1;
      serial_r[wr_idx] <= next_serial_r;
      if (next_serial_r != '1) begin
        next_serial_r <= next_serial_r + SERIAL_BITS'(1);
      end
    end else if (cmd.release_grp) begin
      gate_r[wr_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      for (int g = 0; g < MAX_GROUPS; g++) begin
        note_r[g] <= '0;
      end
    end else if (cmd.stamp) begin
      note_r[wr_idx] <= wr_note;
    end else if (cmd.release_grp) begin
      note_r[wr_idx] <= '0;
    end
  end

  assign rd_gate   = gate_r[rd_idx];
  assign rd_note   = note_r[rd_idx];
  assign rd_serial = serial_r[rd_idx];

endmodule
`default_nettype wire

// File: rtl/core/vga_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vga_scan
// Shared serial comparator and best-candidate tracker, one group per cycle.
// ----------------------------------------------------------------------------
module vga_scan import vga_pkg::*; #(
  parameter int MAX_GROUPS  = DEF_MAX_GROUPS,
  parameter int SERIAL_BITS = DEF_SERIAL_BITS,
  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic                   step,
  input  wire logic                   note_off,
  input  wire scan_elem_t             elem,
  input  wire logic [GW-1:0]          elem_idx,
  input  wire logic [SERIAL_BITS-1:0] elem_serial,
  output logic                        found,
  output logic [GW-1:0]               best_idx,
  output action_t                     best_cls
);

  logic                   found_r;
  logic [GW-1:0]          best_idx_r;
  action_t                best_cls_r;
  logic [SERIAL_BITS-1:0] best_serial_r;

  logic    lt;
  logic    gt;
  action_t cls;
  logic    take;

  // One magnitude comparator serves both the oldest and the newest search.
  assign lt = elem_serial < best_serial_r;
  assign gt = elem_serial > best_serial_r;

  always_comb begin
    if (elem.gate) begin
      cls = ACT_STEAL;
    end else if (elem.env) begin
      cls = ACT_REUSE;
    end else begin
      cls = ACT_IDLE;
    end
    if (note_off) begin
      take = elem.gate && elem.note_eq && (!found_r || gt);
    end else begin
      take = !found_r || (cls < best_cls_r) ||
             ((cls == best_cls_r) && (cls != ACT_IDLE) && lt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (start) begin
      found_r <= 1'b0;
    end else if (step && take) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (step && take) begin
      best_idx_r    <= elem_idx;
      best_cls_r    <= cls;
      best_serial_r <= elem_serial;
    end
  end

  assign found    = found_r;
  assign best_idx = best_idx_r;
  assign best_cls = best_cls_r;

endmodule
`default_nettype wire

// File: rtl/core/voice_group_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// voice_group_allocator_core
// Note-event voice group allocator with oldest-group stealing.
// ----------------------------------------------------------------------------
// Note events enter on in_bus (note on, note off, all notes off) together
// with the envelope activity mask. Each item yields exactly one result item on
// out_bus: the chosen or released group, a matched flag and the action taken.
// The group count is written on cfg_bus while the block is idle; a write that
// changes it clears all groups in the same cycle.
// A note-on or note-off scans the active groups one per cycle through a single
// shared serial comparator, then passes through ST_UPDATE to ST_OUT, where the
// result is presented. All notes off and the unused code go from acceptance
// straight to ST_UPDATE and then ST_OUT. One item is in flight at a time;
// in_bus.ready is high only when no item is held.
// The result stays in the output register while out_bus.ready is low, and no
// new item is accepted until it has been taken.
// Reset is synchronous and active low: group count 1, all gates and serials
// cleared, next serial 1.
// ----------------------------------------------------------------------------
module voice_group_allocator_core import vga_pkg::*; #(
  parameter int MAX_GROUPS  = DEF_MAX_GROUPS,
  parameter int SERIAL_BITS = DEF_SERIAL_BITS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  vga_in_if.sink     in_bus,
  vga_out_if.source  out_bus,
  vga_cfg_if.sink    cfg_bus
);

  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CW = $clog2(MAX_GROUPS + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_OUT    = 4'b1000
  } state_t;

  state_t              st_r, st_nxt;
  op_t                 op_r;
  logic [NOTE_W-1:0]   note_r;
  logic [MASK_W-1:0]   mask_r;
  logic [GW-1:0]       idx_r, idx_nxt;
  logic [ACTIVE_W-1:0] active_r;
  logic [GROUP_W-1:0]  res_group_r;
  logic                res_matched_r;
  action_t             res_action_r;

  logic [CW-1:0]          n_cnt;
  logic                   in_acc;
  logic                   cfg_acc;
  logic                   last_idx;
  grp_cmd_t               cmd;
  logic                   rd_gate;
  logic [NOTE_W-1:0]      rd_note;
  logic [SERIAL_BITS-1:0] rd_serial;
  scan_elem_t             elem;
  logic                   found;
  logic [GW-1:0]          best_idx;
  action_t                best_cls;
  op_t                    in_op;

  assign in_op   = op_t'(in_bus.operation);
  assign in_acc  = in_bus.valid && in_bus.ready;
  assign cfg_acc = cfg_bus.valid && cfg_bus.ready;

  assign in_bus.ready  = (st_r == ST_IDLE);
  assign cfg_bus.ready = (st_r == ST_IDLE);

  always_comb begin
    if (active_r == '0) begin
      n_cnt = CW'(1);
    end else if (32'(active_r) > MAX_GROUPS) begin
      n_cnt = CW'(MAX_GROUPS);
    end else begin
      n_cnt = CW'(active_r);
    end
  end

  assign last_idx = (CW'(idx_r) + CW'(1)) == n_cnt;

  always_comb begin
    elem.gate    = rd_gate;
    elem.env     = (32'(idx_r) < MASK_W) ? mask_r[2'(idx_r)] : 1'b0;
    elem.note_eq = (rd_note == note_r);
  end

  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    case (st_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_acc) begin
          if (in_op == OP_NOTE_ON || in_op == OP_NOTE_OFF) begin
            st_nxt = ST_SCAN;
          end else begin
            st_nxt = ST_UPDATE;
          end
        end
      end
      ST_SCAN: begin
        if (last_idx) begin
          st_nxt = ST_UPDATE;
        end else begin
          idx_nxt = idx_r + GW'(1);
        end
      end
      ST_UPDATE: st_nxt = ST_OUT;
      ST_OUT: begin
        if (out_bus.ready) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.clear       = cfg_acc && (cfg_bus.active_groups != active_r);
    cmd.stamp       = 1'b0;
    cmd.release_grp = 1'b0;
    if (st_r == ST_UPDATE) begin
      case (op_r)
        OP_NOTE_ON:  cmd.stamp = 1'b1;
        OP_NOTE_OFF: cmd.release_grp = found;
        OP_ALL_OFF:  cmd.clear = 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      active_r <= ACTIVE_RESET;
    end else begin
      st_r <= st_nxt;
      if (cfg_acc) begin
        active_r <= cfg_bus.active_groups;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (in_acc) begin
      op_r   <= in_op;
      note_r <= in_bus.note;
      mask_r <= in_bus.env_active_mask;
    end
    if (st_r == ST_UPDATE) begin
      if (op_r == OP_NOTE_ON) begin
        res_group_r   <= GROUP_W'(best_idx);
        res_matched_r <= 1'b1;
        res_action_r  <= best_cls;
      end else if (op_r == OP_NOTE_OFF && found) begin
        res_group_r   <= GROUP_W'(best_idx);
        res_matched_r <= 1'b1;
        res_action_r  <= ACT_NONE;
      end else begin
        res_group_r   <= '0;
        res_matched_r <= 1'b0;
        res_action_r  <= ACT_NONE;
      end
    end
  end

  vga_group_regs #(
    .MAX_GROUPS  (MAX_GROUPS),
    .SERIAL_BITS (SERIAL_BITS)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .wr_idx    (best_idx),
    .wr_note   (note_r),
    .rd_idx    (idx_r),
    .rd_gate   (rd_gate),
    .rd_note   (rd_note),
    .rd_serial (rd_serial)
  );

  vga_scan #(
    .MAX_GROUPS  (MAX_GROUPS),
    .SERIAL_BITS (SERIAL_BITS)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_acc),
    .step        (st_r == ST_SCAN),
    .note_off    (op_r == OP_NOTE_OFF),
    .elem        (elem),
    .elem_idx    (idx_r),
    .elem_serial (rd_serial),
    .found       (found),
    .best_idx    (best_idx),
    .best_cls    (best_cls)
  );

  assign out_bus.valid   = (st_r == ST_OUT);
  assign out_bus.group   = res_group_r;
  assign out_bus.matched = res_matched_r;
  assign out_bus.action  = res_action_r;

`ifndef SYNTHESIS
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> !in_bus.ready)
    else $error("input accepted while a result is pending");

  a_note_event_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_op == OP_NOTE_ON || in_op == OP_NOTE_OFF)) |=> (st_r == ST_SCAN))
    else $error("note event did not start a group scan");

  a_note_on_matched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && op_r == OP_NOTE_ON) |-> (out_bus.matched && out_bus.action != ACT_NONE))
    else $error("note-on result without an assigned group");

  a_unmatched_is_none: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && !out_bus.matched) |-> (out_bus.action == ACT_NONE && out_bus.group == '0))
    else $error("unmatched result carries a group or action");
`endif

endmodule
`default_nettype wire

// File: tb/sv/tb_voice_group_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_voice_group_allocator_core
// Self-checking bench for the voice group allocator core.
// ----------------------------------------------------------------------------
// Note events are queued by a stimulus process and presented by a clocked
// driver. Every accepted item runs through a behavioral allocator that keeps
// its own gates, held notes and serials, and the predicted group, match flag
// and action are queued. A clocked monitor takes each result item and checks
// it against the oldest prediction. The run covers a short directed sequence,
// then random phases at different group counts and handshake pacing modes.
// ----------------------------------------------------------------------------
module tb_voice_group_allocator_core;
  import vga_pkg::*;

  localparam int MAX_GROUPS   = DEF_MAX_GROUPS;
  localparam int SERIAL_BITS  = DEF_SERIAL_BITS;
  localparam int PHASE_EVENTS = 88;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 30;

  typedef struct packed {
    op_t               op;
    logic [NOTE_W-1:0] note;
    logic [MASK_W-1:0] mask;
  } note_event_t;

  typedef struct packed {
    logic [GROUP_W-1:0] group;
    logic               matched;
    action_t            action;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n;

  vga_in_if  in_bus ();
  vga_out_if out_bus ();
  vga_cfg_if cfg_bus ();

  voice_group_allocator_core #(
    .MAX_GROUPS (MAX_GROUPS),
    .SERIAL_BITS(SERIAL_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  always #5 clk = ~clk;

  logic [ACTIVE_W-1:0]    group_count_reg;
  logic                   gate_on [MAX_GROUPS];
  logic [NOTE_W-1:0]      held_note [MAX_GROUPS];
  logic [SERIAL_BITS-1:0] stamp [MAX_GROUPS];
  logic [SERIAL_BITS-1:0] next_stamp;

  note_event_t   pending_events[$];
  alloc_result_t expected_results[$];

  int in_flight      = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int n_events       = 0;
  int n_results      = 0;
  int n_cfg_writes   = 0;
  int n_errors       = 0;
  int cycle_count    = 0;

  function automatic void clear_groups();
    for (int g = 0; g < MAX_GROUPS; g++) begin
      gate_on[g]   = 1'b0;
      held_note[g] = '0;
      stamp[g]     = '0;
    end
    next_stamp = SERIAL_BITS'(1);
  endfunction

  function automatic alloc_result_t allocate_voice(op_t op, logic [NOTE_W-1:0] note,
                                                   logic [MASK_W-1:0] mask);
    alloc_result_t res;
    int count;
    int pick;
    res.group   = '0;
    res.matched = 1'b0;
    res.action  = ACT_NONE;
    if (group_count_reg == 0) begin
      count = 1;
    end else if (group_count_reg > MAX_GROUPS) begin
      count = MAX_GROUPS;
    end else begin
      count = int'(group_count_reg);
    end
    case (op)
      OP_NOTE_ON: begin
        pick = -1;
        res.action = ACT_IDLE;
        for (int g = 0; g < count && pick < 0; g++) begin
          if (!gate_on[g] && !(g < MASK_W && mask[g])) pick = g;
        end
        if (pick < 0) begin
          for (int g = 0; g < count; g++) begin
            if (!gate_on[g] && g < MASK_W && mask[g] && (pick < 0 || stamp[g] < stamp[pick]))
              pick = g;
          end
          res.action = ACT_REUSE;
        end
        if (pick < 0) begin
          pick = 0;
          for (int g = 1; g < count; g++) begin
            if (stamp[g] < stamp[pick]) pick = g;
          end
          res.action = ACT_STEAL;
        end
        gate_on[pick]   = 1'b1;
        held_note[pick] = note;
        stamp[pick]     = next_stamp;
        if (next_stamp != '1) next_stamp = next_stamp + SERIAL_BITS'(1);
        res.group   = GROUP_W'(pick);
        res.matched = 1'b1;
      end
      OP_NOTE_OFF: begin
        pick = -1;
        for (int g = 0; g < count; g++) begin
          if (gate_on[g] && held_note[g] == note && (pick < 0 || stamp[g] > stamp[pick]))
            pick = g;
        end
        if (pick >= 0) begin
          gate_on[pick]   = 1'b0;
          held_note[pick] = '0;
          res.group       = GROUP_W'(pick);
          res.matched     = 1'b1;
        end
      end
      OP_ALL_OFF: begin
        clear_groups();
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_results.push_back(allocate_voice(op_t'(in_bus.operation), in_bus.note,
                                                  in_bus.env_active_mask));
        n_events++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_events.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin : present
          note_event_t ev;
          ev = pending_events.pop_front();
          in_flight++;
          in_bus.valid           <= 1'b1;
          in_bus.operation       <= ev.op;
          in_bus.note            <= ev.note;
          in_bus.env_active_mask <= ev.mask;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    alloc_result_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        n_results++;
        in_flight--;
        if (expected_results.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: unexpected result item group %0d matched %0d action %0d",
                     $time, out_bus.group, out_bus.matched, out_bus.action);
        end else begin
          want = expected_results.pop_front();
          if (out_bus.group !== want.group) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("%0t: group mismatch, expected %0d, actual %0d",
                       $time, want.group, out_bus.group);
          end
          if (out_bus.matched !== want.matched) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("%0t: matched mismatch, expected %0d, actual %0d",
                       $time, want.matched, out_bus.matched);
          end
          if (out_bus.action !== want.action) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("%0t: action mismatch, expected %0d, actual %0d",
                       $time, want.action, out_bus.action);
          end
        end
      end
      out_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d items in flight", $time, in_flight);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_event(op_t op, int note, int mask);
    note_event_t ev;
    ev.op   = op;
    ev.note = NOTE_W'(note);
    ev.mask = MASK_W'(mask);
    pending_events.push_back(ev);
  endtask

  task automatic wait_idle();
    while (pending_events.size() != 0 || in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_group_count(logic [ACTIVE_W-1:0] value);
    wait_idle();
    cfg_bus.valid         <= 1'b1;
    cfg_bus.active_groups <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (value != group_count_reg) begin
      group_count_reg = value;
      clear_groups();
    end
    n_cfg_writes++;
  endtask

  initial begin : stimulus
    logic [ACTIVE_W-1:0] phase_counts [8];
    logic [NOTE_W-1:0]   note_pool [6];
    int r;
    op_t op;

    phase_counts = '{3'd4, 3'd2, 3'd0, 3'd3, 3'd7, 3'd1, 3'd6, 3'd5};
    rst_n                  = 1'b0;
    in_bus.valid           = 1'b0;
    in_bus.operation       = OP_NOTE_ON;
    in_bus.note            = '0;
    in_bus.env_active_mask = '0;
    out_bus.ready          = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.active_groups  = ACTIVE_RESET;
    group_count_reg        = ACTIVE_RESET;
    clear_groups();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // In mono mode, a note-on into a gated group steals it even when the
    // mask bits of unused groups are set.
    queue_event(OP_NOTE_ON, 0, 4'h0);
    queue_event(OP_NOTE_ON, 127, 4'hF);
    queue_event(OP_NOTE_OFF, 127, 4'h0);
    queue_event(OP_NOTE_OFF, 127, 4'h0);
    queue_event(OP_NOTE_ON, 5, 4'h1);
    queue_event(OP_NOTE_ON, 9, 4'hE);
    queue_event(OP_ALL_OFF, 9, 4'h0);
    queue_event(OP_UNUSED, 127, 4'hF);

    write_group_count(3'd4);
    queue_event(OP_NOTE_ON, 10, 4'h0);
    queue_event(OP_NOTE_ON, 10, 4'h0);
    queue_event(OP_NOTE_ON, 30, 4'h0);
    queue_event(OP_NOTE_ON, 40, 4'h0);
    queue_event(OP_NOTE_OFF, 10, 4'h0);
    queue_event(OP_NOTE_OFF, 10, 4'h0);
    queue_event(OP_NOTE_ON, 50, 4'hF);
    queue_event(OP_NOTE_ON, 60, 4'h0);
    queue_event(OP_NOTE_ON, 70, 4'h0);
    queue_event(OP_NOTE_ON, 0, 4'h5);
    queue_event(OP_NOTE_OFF, 0, 4'hF);
    queue_event(OP_NOTE_OFF, 99, 4'h0);
    queue_event(OP_ALL_OFF, 127, 4'hF);
    queue_event(OP_NOTE_ON, 127, 4'hA);
    queue_event(OP_UNUSED, 0, 4'h0);

    for (int phase = 0; phase < 8; phase++) begin
      write_group_count(phase_counts[phase]);
      case (phase % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 58; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 58; end
        default: begin src_idle_pct = 34; sink_stall_pct = 34; end
      endcase
      for (int k = 0; k < 6; k++) note_pool[k] = NOTE_W'($urandom_range(0, 127));
      note_pool[0] = (phase % 2) ? NOTE_W'(127) : NOTE_W'(0);
      for (int k = 0; k < PHASE_EVENTS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 55) op = OP_NOTE_ON;
        else if (r < 88) op = OP_NOTE_OFF;
        else if (r < 94) op = OP_ALL_OFF;
        else op = OP_UNUSED;
        queue_event(op,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                : note_pool[$urandom_range(0, 5)],
                    $urandom_range(0, 15));
      end
    end

    wait_idle();
    $display("Ran %0d note events through %0d group count writes and four pacing modes.",
             n_events, n_cfg_writes);
    $display("Checked %0d result items, %0d mismatches found.", n_results, n_errors);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
